// ===== rtl/wrsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the windowed running sum / average block.
// No dependencies; every other file imports this package.
package wrsa_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 16;

	localparam int POS_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int COUNT_BITS = $clog2(WINDOW_MAX + 1);
	localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int AVG_BITS   = SAMPLE_BITS;
	localparam int SIZE_BITS  = 7;

	localparam int DIV_STEPS    = SUM_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam int REG_BITS   = PADDR_BITS - 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;
	typedef logic signed [AVG_BITS-1:0]    avg_t;
	typedef logic        [COUNT_BITS-1:0]  count_t;
	typedef logic        [POS_BITS-1:0]    pos_t;
	typedef logic        [SIZE_BITS-1:0]   wsize_t;

	localparam wsize_t SIZE_RESET = SIZE_BITS'(64);

	// register indexes
	localparam logic [REG_BITS-1:0] REG_WINDOW_SIZE = REG_BITS'(0);

	// item function codes
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

endpackage

// ===== rtl/wrsa_if.sv =====
`timescale 1ns / 1ps
// Handshake channels for input items and result beats.
// Depends on wrsa_pkg.
interface wrsa_item_if import wrsa_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    func;
	sample_t sample;

	modport source (output valid, output func, output sample, input ready);
	modport sink (input valid, input func, input sample, output ready);
endinterface

interface wrsa_result_if import wrsa_pkg::*; ();
	logic   valid;
	logic   ready;
	sum_t   window_sum;
	count_t window_count;
	logic   window_full;
	logic   window_empty;
	avg_t   window_average;

	modport source (output valid, output window_sum, output window_count,
		output window_full, output window_empty, output window_average, input ready);
	modport sink (input valid, input window_sum, input window_count,
		input window_full, input window_empty, input window_average, output ready);
endinterface

// ===== rtl/windowed_running_sum_average.sv =====
`timescale 1ns / 1ps
// Windowed running sum and average over the last window_size signed samples.
// Depends on wrsa_pkg, wrsa_if, wrsa_ring and wrsa_div.
//
// One item is in flight at a time, from acceptance until its result beat is
// loaded. The ring read issues at the accepting edge. Then come the update and
// write-back (ST_UPD), the divider launch (ST_START), the one-bit-per-cycle
// divider that forms the average (ST_WAIT), and the load of the output
// register. The next item can be accepted the cycle after the load. The output
// register decouples the result side, so a waiting result does not stop the
// next item from being accepted. Only that item's load waits for the beat to be
// taken. A func of 1 clears the window; writing window_size (address 0) also
// clears it. window_size 0 acts as 1, and values above 64 act as 64.
module windowed_running_sum_average import wrsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	wrsa_item_if.sink             item,
	wrsa_result_if.source         result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_START,
		ST_WAIT
	} state_t;

	state_t  state_q;
	wsize_t  window_size_q;
	pos_t    wpos_q;
	count_t  held_count_q;
	sum_t    running_total_q;

	logic    func_s1;
	sample_t sample_s1;
	pos_t    pos_s1;

	logic    res_valid_q;
	sum_t    res_sum_q;
	count_t  res_count_q;
	logic    res_full_q;
	logic    res_empty_q;
	avg_t    res_avg_q;

	count_t  eff_size;
	pos_t    pos_eff;
	count_t  pos_inc;
	pos_t    wpos_next;
	logic    win_full;
	sum_t    total_next;
	sample_t rd_data;
	logic    accept;
	logic    cfg_we;
	logic    div_start;
	logic    div_busy;
	avg_t    div_quo;
	logic    res_load;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite
		&& (paddr[PADDR_BITS-1:2] == REG_WINDOW_SIZE);
	assign prdata = (paddr[PADDR_BITS-1:2] == REG_WINDOW_SIZE)
		? PDATA_BITS'(window_size_q) : '0;

	always_comb begin
		if (window_size_q == '0) begin
			eff_size = COUNT_BITS'(1);
		end else if (32'(window_size_q) > WINDOW_MAX) begin
			eff_size = COUNT_BITS'(WINDOW_MAX);
		end else begin
			eff_size = COUNT_BITS'(window_size_q);
		end
	end

	assign accept  = item.valid && item.ready;
	assign pos_eff = (COUNT_BITS'(wpos_q) >= eff_size) ? '0 : wpos_q;

	assign pos_inc   = COUNT_BITS'(pos_s1) + COUNT_BITS'(1);
	assign wpos_next = (pos_inc >= eff_size) ? '0 : pos_inc[POS_BITS-1:0];
	assign win_full  = (held_count_q >= eff_size);
	assign total_next = running_total_q - (win_full ? sum_t'(rd_data) : '0)
		+ sum_t'(sample_s1);

	wrsa_ring u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPD && func_s1 == FUNC_ADD),
		.waddr (pos_s1),
		.wdata (sample_s1),
		.re    (accept),
		.raddr (pos_eff),
		.rdata (rd_data)
	);

	assign div_start = (state_q == ST_START);

	wrsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (running_total_q),
		.divisor  (held_count_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign res_load = (state_q == ST_WAIT) && !div_busy && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_size_q   <= SIZE_RESET;
			wpos_q          <= '0;
			held_count_q    <= '0;
			running_total_q <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				window_size_q   <= pwdata[SIZE_BITS-1:0];
				wpos_q          <= '0;
				held_count_q    <= '0;
				running_total_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (func_s1 == FUNC_CLEAR) begin
						wpos_q          <= '0;
						held_count_q    <= '0;
						running_total_q <= '0;
					end else begin
						wpos_q          <= wpos_next;
						running_total_q <= total_next;
						if (!win_full) begin
							held_count_q <= held_count_q + 1'b1;
						end
					end
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= item.func;
			sample_s1 <= item.sample;
			pos_s1    <= pos_eff;
		end
		if (res_load) begin
			res_sum_q   <= running_total_q;
			res_count_q <= held_count_q;
			res_full_q  <= (held_count_q == eff_size);
			res_empty_q <= (held_count_q == '0);
			res_avg_q   <= (held_count_q == '0) ? '0 : div_quo;
		end
	end

	assign item.ready            = (state_q == ST_IDLE);
	assign result.valid          = res_valid_q;
	assign result.window_sum     = res_sum_q;
	assign result.window_count   = res_count_q;
	assign result.window_full    = res_full_q;
	assign result.window_empty   = res_empty_q;
	assign result.window_average = res_avg_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= eff_size)
		else $error("held count exceeds window size");

	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		COUNT_BITS'(wpos_q) < eff_size)
		else $error("write position outside window");

	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_UPD)
		else $error("accepted item did not start update");

	a_empty_avg: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_empty_q |-> res_avg_q == '0 && res_sum_q == '0)
		else $error("empty window with nonzero average or sum");
`endif

endmodule

// ===== rtl/wrsa_ring.sv =====
`timescale 1ns / 1ps
// Sample ring: single write port, single read port, registered read data.
// Depends on wrsa_pkg.
module wrsa_ring import wrsa_pkg::*; (
	input  logic    clk,
	input  logic    we,
	input  pos_t    waddr,
	input  sample_t wdata,
	input  logic    re,
	input  pos_t    raddr,
	output sample_t rdata
);

	sample_t mem [WINDOW_MAX];
	sample_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/wrsa_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: signed sum / unsigned count.
// Quotient truncates toward zero. Depends on wrsa_pkg.
module wrsa_div import wrsa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  sum_t   dividend,
	input  count_t divisor,
	output logic   busy,
	output avg_t   quotient
);

	logic                    busy_q;
	logic [DIV_CNT_BITS-1:0] step_q;
	count_t                  rem_q;
	count_t                  div_q;
	logic [SUM_BITS-1:0]     quo_q;
	logic                    neg_q;

	logic [SUM_BITS-1:0]   mag;
	logic [COUNT_BITS+1:0] diff;
	logic                  borrow;
	logic [AVG_BITS-1:0]   quo_low;

	assign mag    = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
	assign diff   = {1'b0, rem_q, quo_q[SUM_BITS-1]} - {2'b00, div_q};
	assign borrow = diff[COUNT_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= mag;
			neg_q <= dividend[SUM_BITS-1];
		end else if (busy_q) begin
			// remainder stays below the divisor, so both arms fit COUNT_BITS
			rem_q <= borrow ? {rem_q[COUNT_BITS-2:0], quo_q[SUM_BITS-1]}
				: diff[COUNT_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], ~borrow};
		end
	end

	assign quo_low  = quo_q[AVG_BITS-1:0];
	assign busy     = busy_q;
	assign quotient = neg_q ? avg_t'(-quo_low) : avg_t'(quo_low);

endmodule

// ===== sim/windowed_running_sum_average_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for windowed_running_sum_average: random sample beats against a
// behavioral window model, with window_size rewritten over the APB port between phases.
// Depends on wrsa_pkg, wrsa_if and the RTL of the block.
module windowed_running_sum_average_test;
	import wrsa_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 33;

	localparam logic [PADDR_BITS-1:0] SIZE_ADDR   = {REG_WINDOW_SIZE, 2'b00};
	// no register lives at index 1; writes there must be dropped
	localparam logic [REG_BITS-1:0]   REG_NONE    = REG_BITS'(1);
	localparam logic [PADDR_BITS-1:0] UNUSED_ADDR = {REG_NONE, 2'b00};

	localparam sample_t SAMPLE_MAX = sample_t'(32767);
	localparam sample_t SAMPLE_MIN = sample_t'(-32768);

	typedef struct {
		logic    func;
		sample_t sample;
	} window_item_t;

	typedef struct {
		sum_t   sum;
		count_t count;
		logic   full;
		logic   empty;
		avg_t   average;
	} window_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	wrsa_item_if   sample_beats();
	wrsa_result_if result_beats();

	windowed_running_sum_average i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (sample_beats),
		.result  (result_beats),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// window model
	sample_t ring_model [WINDOW_MAX];
	pos_t    next_slot;
	count_t  held;
	sum_t    total;
	wsize_t  size_reg;

	window_item_t   queued_samples[$];
	window_result_t predicted_windows[$];

	int   items_queued;
	int   items_accepted;
	int   mismatches;
	int   idle_cycles;
	logic calm;
	logic sample_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 100)
			$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic void clear_window();
		next_slot = '0;
		held      = '0;
		total     = '0;
	endfunction

	function automatic int active_size();
		int n;
		n = int'(size_reg);
		if (n < 1)
			n = 1;
		if (n > WINDOW_MAX)
			n = WINDOW_MAX;
		return n;
	endfunction

	function automatic window_result_t advance_window(input window_item_t it);
		window_result_t r;
		int n;
		int slot;
		n = active_size();
		if (it.func == FUNC_CLEAR) begin
			clear_window();
		end else begin
			slot = int'(next_slot);
			if (slot >= n)
				slot = 0;
			// a full window drops its oldest sample before taking the new one
			if (int'(held) >= n)
				total = total - sum_t'(ring_model[slot]);
			else
				held = held + 1'b1;
			total = total + sum_t'(it.sample);
			ring_model[slot] = it.sample;
			slot++;
			next_slot = (slot >= n) ? pos_t'(0) : pos_t'(slot);
		end
		r.sum     = total;
		r.count   = held;
		r.full    = (int'(held) == n);
		r.empty   = (held == '0);
		r.average = (held == '0) ? avg_t'(0) : avg_t'(int'(total) / int'(held));
		return r;
	endfunction

	task automatic queue_sample(input logic func, input sample_t s);
		window_item_t it;
		it.func   = func;
		it.sample = s;
		queued_samples.push_back(it);
		items_queued++;
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(int'($urandom_range(20)) - 10);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic write_register(input logic [PADDR_BITS-1:0] addr,
		input logic [PDATA_BITS-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr[PADDR_BITS-1:2] == REG_WINDOW_SIZE) begin
			size_reg = data[SIZE_BITS-1:0];
			clear_window();
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_size_reg();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= SIZE_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[SIZE_BITS-1:0] !== size_reg)
			report_mismatch("window_size readback", prdata[SIZE_BITS-1:0], size_reg);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// block is idle once every queued beat went in and every result came back
	task automatic wait_idle();
		while (items_accepted != items_queued || predicted_windows.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	always @(negedge clk) begin : drive_samples
		window_item_t next_item;
		if (!arst_n) begin
			sample_beats.valid <= 1'b0;
		end else if (!sample_beats.valid || sample_taken) begin
			if (queued_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				next_item = queued_samples.pop_front();
				sample_beats.valid  <= 1'b1;
				sample_beats.func   <= next_item.func;
				sample_beats.sample <= next_item.sample;
			end else begin
				sample_beats.valid <= 1'b0;
			end
		end
		result_beats.ready <= arst_n && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : watch_beats
		window_item_t   it;
		window_result_t want;
		logic           result_taken;
		sample_taken = 1'b0;
		if (arst_n) begin
			result_taken = result_beats.valid && result_beats.ready;
			if (result_taken) begin
				if (predicted_windows.size() == 0) begin
					report_mismatch("result beat with nothing outstanding",
						result_beats.window_sum, 0);
				end else begin
					want = predicted_windows.pop_front();
					if (result_beats.window_sum !== want.sum)
						report_mismatch("window_sum", result_beats.window_sum, want.sum);
					if (result_beats.window_count !== want.count)
						report_mismatch("window_count", result_beats.window_count, want.count);
					if (result_beats.window_full !== want.full)
						report_mismatch("window_full", result_beats.window_full, want.full);
					if (result_beats.window_empty !== want.empty)
						report_mismatch("window_empty", result_beats.window_empty, want.empty);
					if (result_beats.window_average !== want.average)
						report_mismatch("window_average", result_beats.window_average,
							want.average);
				end
			end
			sample_taken = sample_beats.valid && sample_beats.ready;
			if (sample_taken) begin
				it.func   = sample_beats.func;
				it.sample = sample_beats.sample;
				predicted_windows.push_back(advance_window(it));
				items_accepted++;
			end
			if (sample_taken || result_taken || (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("windowed_running_sum_average test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int size_pick;
		int clear_pct;
		logic [PDATA_BITS-1:0] data;
		sample_beats.valid  = 1'b0;
		sample_beats.func   = FUNC_ADD;
		sample_beats.sample = '0;
		result_beats.ready  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		calm           = 1'b0;
		sample_taken   = 1'b0;
		items_queued   = 0;
		items_accepted = 0;
		mismatches     = 0;
		idle_cycles    = 0;
		size_reg       = SIZE_RESET;
		clear_window();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window of 64: extremes, clears on empty, negative truncation
		check_size_reg();
		queue_sample(FUNC_ADD, SAMPLE_MAX);
		queue_sample(FUNC_ADD, SAMPLE_MIN);
		queue_sample(FUNC_ADD, sample_t'(1));
		queue_sample(FUNC_ADD, sample_t'(-1));
		queue_sample(FUNC_ADD, sample_t'(0));
		queue_sample(FUNC_ADD, sample_t'(-7));
		queue_sample(FUNC_CLEAR, SAMPLE_MAX);
		queue_sample(FUNC_CLEAR, sample_t'(0));
		queue_sample(FUNC_ADD, sample_t'(-7));
		queue_sample(FUNC_ADD, sample_t'(2));
		queue_sample(FUNC_ADD, sample_t'(2));
		wait_idle();

		// window of 2: eviction of the oldest sample
		write_register(SIZE_ADDR, PDATA_BITS'(2));
		check_size_reg();
		queue_sample(FUNC_ADD, sample_t'(5));
		queue_sample(FUNC_ADD, sample_t'(6));
		queue_sample(FUNC_ADD, sample_t'(7));
		queue_sample(FUNC_ADD, SAMPLE_MIN);
		queue_sample(FUNC_CLEAR, sample_t'(-1));
		queue_sample(FUNC_ADD, sample_t'(3));
		wait_idle();

		// size 0 behaves as 1; upper data bits are not part of the register
		write_register(SIZE_ADDR, 32'hFFFF_FF80);
		check_size_reg();
		queue_sample(FUNC_ADD, sample_t'(10));
		queue_sample(FUNC_ADD, sample_t'(-10));
		wait_idle();

		// write to a hole in the map: window and size must survive
		write_register(UNUSED_ADDR, PDATA_BITS'(5));
		check_size_reg();
		queue_sample(FUNC_ADD, sample_t'(4));
		wait_idle();

		// sizes above 64 clamp; drive the sum to both ends of its range
		write_register(SIZE_ADDR, PDATA_BITS'(127));
		check_size_reg();
		repeat (70) queue_sample(FUNC_ADD, SAMPLE_MAX);
		repeat (70) queue_sample(FUNC_ADD, SAMPLE_MIN);
		wait_idle();

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: size_pick = 1;
				1: size_pick = 3;
				2: size_pick = 65;
				3: size_pick = 0;
				4: size_pick = 64;
				5: size_pick = $urandom_range(16, 2);
				6: size_pick = 127;
				7: size_pick = $urandom_range(127, 1);
				8: size_pick = $urandom_range(40, 4);
				default: size_pick = 5;
			endcase
			data = $urandom;
			data[SIZE_BITS-1:0] = SIZE_BITS'(size_pick);
			write_register(SIZE_ADDR, data);
			check_size_reg();
			calm = (phase == 4);
			clear_pct = (active_size() >= 32) ? 1 : 6;
			repeat (80) begin
				if ($urandom_range(99) < clear_pct)
					queue_sample(FUNC_CLEAR, sample_t'($urandom));
				else
					queue_sample(FUNC_ADD, pick_sample());
			end
			wait_idle();
			calm = 1'b0;
		end

		// catch any stray result beats
		repeat (30) @(negedge clk);
		if (mismatches == 0)
			$display("windowed_running_sum_average test passed");
		else
			$display("windowed_running_sum_average test failed");
		$finish;
	end

endmodule

// ===== windowed_running_sum_average.f =====
rtl/wrsa_pkg.sv
rtl/wrsa_if.sv
rtl/wrsa_ring.sv
rtl/wrsa_div.sv
rtl/windowed_running_sum_average.sv
sim/windowed_running_sum_average_test.sv
